// ----- hdl/pid_step_pkg.sv -----
// Package: types and constants shared by the PID step unit.
`timescale 1ns / 1ps
package pid_step_pkg;

    localparam int DATA_W   = 32;
    localparam int TIME_W   = 31;
    localparam int ERR_W    = 33;
    localparam int DIFF_W   = 34;
    localparam int INTEG_W  = 34;
    localparam int WIDE_W   = 50;
    localparam int OPA_W    = 34;
    localparam int OPB_W    = 64;
    localparam int CHUNK_W  = 16;
    localparam int PP_W     = OPA_W + CHUNK_W + 1;
    localparam int ACC_W    = 88;
    localparam int QPROD_W  = ACC_W - CHUNK_W;
    localparam int FRAC_W   = 16;
    localparam int STEPS    = OPB_W / CHUNK_W;
    localparam int STEP_W   = $clog2(STEPS);
    localparam int CFG_IDX_W = 3;

    localparam logic signed [WIDE_W-1:0] Q_ONE_POS = 50'sd65536;
    localparam logic signed [WIDE_W-1:0] Q_ONE_NEG = -50'sd65536;

    localparam logic [CFG_IDX_W-1:0] REG_KP      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KI      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_KD      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DT      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_DT_RCP  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_OUT_MAX = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_OUT_MIN = 3'd6;

    localparam logic ACTION_COMPUTE = 1'b0;
    localparam logic ACTION_PRESET  = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL,
        ST_WB,
        ST_DONE
    } state_t;

    typedef enum logic [2:0] {
        OP_ERR_DT,
        OP_DIFF_RCP,
        OP_KP,
        OP_KI,
        OP_KD
    } op_t;

endpackage

// ----- hdl/pid_controller_step_unit.sv -----
// PID step unit: shared multiplier under a sequencer, clamped Q16.16 output.
`timescale 1ns / 1ps
// Usage:
//   Input channel (in_valid/in_stall): action 0 runs a control step on
//   target/measured, action 1 loads preset_value into the integral and
//   gives no transaction on the output.
//   Output channel (out_valid/out_stall): one drive value per compute step.
//   Config channel (cfg_valid/cfg_ready/cfg_index/cfg_data): gains, dt,
//   1/dt and output limits; ready is always high. Write only while idle.
// Timing:
//   A preset loads the integral on acceptance and leaves the unit idle. A
//   compute step runs five products through one 34x17 multiplier, four
//   16-bit slices each, plus a writeback state per product. in_stall is
//   high for the whole step, so no new item is accepted until it is idle.
//   The output register holds a finished result while the next item is
//   accepted; a step that finishes while the previous result is still
//   stalled waits in its final state until the output register frees up.
// Reset: rst_n clears state, integral, last error and loads register defaults.
module pid_controller_step_unit
    import pid_step_pkg::*;
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic                        action,
    input  logic signed [DATA_W-1:0]    target,
    input  logic signed [DATA_W-1:0]    measured,
    input  logic signed [DATA_W-1:0]    preset_value,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic signed [DATA_W-1:0]    drive,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [CFG_IDX_W-1:0]        cfg_index,
    input  logic [DATA_W-1:0]           cfg_data
);

    state_t state_reg, state_next;
    op_t    op_reg, op_next;
    logic [STEP_W-1:0] step_reg, step_next;

    logic signed [DATA_W-1:0]  kp_reg, ki_reg, kd_reg, out_max_reg, out_min_reg;
    logic [TIME_W-1:0]         dt_reg, dt_rcp_reg;

    logic signed [INTEG_W-1:0] integ_reg, integ_next;
    logic signed [ERR_W-1:0]   last_err_reg, last_err_next;
    logic signed [ERR_W-1:0]   err_reg, err_next;
    logic signed [WIDE_W-1:0]  ipre_reg, ipre_next;
    logic signed [WIDE_W-1:0]  deriv_reg, deriv_next;
    logic signed [QPROD_W-1:0] sum_reg, sum_next;
    logic signed [OPA_W-1:0]   op_a_reg, op_a_next;
    logic [OPB_W-1:0]          op_b_reg, op_b_next;
    logic [ACC_W-1:0]          acc_reg, acc_next;
    logic                      out_valid_reg, out_valid_next;
    logic signed [DATA_W-1:0]  drive_reg, drive_next;

    logic                      in_accept;
    logic                      out_free;
    logic signed [CHUNK_W:0]   chunk;
    logic signed [PP_W-1:0]    pp;
    logic signed [QPROD_W-1:0] prod_q;
    logic signed [DIFF_W-1:0]  diff;
    logic signed [QPROD_W-1:0] out_max_w, out_min_w;
    logic signed [DATA_W-1:0]  res;

    assign in_stall  = (state_reg != ST_IDLE);
    assign in_accept = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign drive     = drive_reg;

    // Shared multiplier: op_a times one 16-bit slice of op_b, MSB slice first.
    assign chunk  = (step_reg == '0) ? $signed({op_b_reg[OPB_W-1], op_b_reg[OPB_W-1 -: CHUNK_W]})
                                     : $signed({1'b0, op_b_reg[OPB_W-1 -: CHUNK_W]});
    assign pp     = PP_W'(op_a_reg) * PP_W'(chunk);
    assign prod_q = $signed(acc_reg[ACC_W-1:FRAC_W]);
    assign diff   = DIFF_W'(err_reg) - DIFF_W'(last_err_reg);

    assign out_max_w = QPROD_W'(out_max_reg);
    assign out_min_w = QPROD_W'(out_min_reg);

    always_comb
    begin
        if (sum_reg > out_max_w)
            res = out_max_reg;
        else if (sum_reg < out_min_w)
            res = out_min_reg;
        else
            res = sum_reg[DATA_W-1:0];
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_accept && action == ACTION_COMPUTE)
                    state_next = ST_MUL;
            end
            ST_MUL:
            begin
                if (step_reg == STEP_W'(STEPS - 1))
                    state_next = ST_WB;
            end
            ST_WB:
            begin
                if (op_reg == OP_KD)
                    state_next = ST_DONE;
                else
                    state_next = ST_MUL;
            end
            ST_DONE:
            begin
                if (out_free)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Datapath and outputs
    always_comb
    begin
        op_next        = op_reg;
        step_next      = step_reg;
        integ_next     = integ_reg;
        last_err_next  = last_err_reg;
        err_next       = err_reg;
        ipre_next      = ipre_reg;
        deriv_next     = deriv_reg;
        sum_next       = sum_reg;
        op_a_next      = op_a_reg;
        op_b_next      = op_b_reg;
        acc_next       = acc_reg;
        drive_next     = drive_reg;
        out_valid_next = out_valid_reg && out_stall;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    if (action == ACTION_PRESET)
                    begin
                        integ_next = INTEG_W'(preset_value);
                    end
                    else
                    begin
                        err_next  = ERR_W'(target) - ERR_W'(measured);
                        op_a_next = OPA_W'(err_next);
                        op_b_next = OPB_W'(dt_reg);
                        op_next   = OP_ERR_DT;
                        step_next = '0;
                        acc_next  = '0;
                    end
                end
            end
            ST_MUL:
            begin
                acc_next  = {acc_reg[ACC_W-CHUNK_W-1:0], {CHUNK_W{1'b0}}}
                            + ACC_W'(pp);
                op_b_next = {op_b_reg[OPB_W-CHUNK_W-1:0], {CHUNK_W{1'b0}}};
                step_next = step_reg + 1'b1;
            end
            ST_WB:
            begin
                acc_next  = '0;
                step_next = '0;
                case (op_reg)
                    OP_ERR_DT:
                    begin
                        ipre_next = WIDE_W'(integ_reg) + prod_q[WIDE_W-1:0];
                        op_a_next = OPA_W'(diff);
                        op_b_next = OPB_W'(dt_rcp_reg);
                        op_next   = OP_DIFF_RCP;
                    end
                    OP_DIFF_RCP:
                    begin
                        deriv_next = prod_q[WIDE_W-1:0];
                        op_a_next  = OPA_W'(kp_reg);
                        op_b_next  = OPB_W'(err_reg);
                        op_next    = OP_KP;
                    end
                    OP_KP:
                    begin
                        sum_next  = prod_q;
                        op_a_next = OPA_W'(ki_reg);
                        op_b_next = OPB_W'(ipre_reg);
                        op_next   = OP_KI;
                    end
                    OP_KI:
                    begin
                        sum_next  = sum_reg + prod_q;
                        op_a_next = OPA_W'(kd_reg);
                        op_b_next = OPB_W'(deriv_reg);
                        op_next   = OP_KD;
                    end
                    OP_KD:
                    begin
                        sum_next      = sum_reg + prod_q;
                        last_err_next = err_reg;
                        if (ipre_reg > Q_ONE_POS)
                            integ_next = INTEG_W'(Q_ONE_POS);
                        else if (ipre_reg < Q_ONE_NEG)
                            integ_next = INTEG_W'(Q_ONE_NEG);
                        else
                            integ_next = ipre_reg[INTEG_W-1:0];
                    end
                    default: op_next = OP_ERR_DT;
                endcase
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    drive_next     = res;
                    out_valid_next = 1'b1;
                end
            end
            default: op_next = op_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            op_reg        <= OP_ERR_DT;
            step_reg      <= '0;
            integ_reg     <= '0;
            last_err_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            op_reg        <= op_next;
            step_reg      <= step_next;
            integ_reg     <= integ_next;
            last_err_reg  <= last_err_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        err_reg   <= err_next;
        ipre_reg  <= ipre_next;
        deriv_reg <= deriv_next;
        sum_reg   <= sum_next;
        op_a_reg  <= op_a_next;
        op_b_reg  <= op_b_next;
        acc_reg   <= acc_next;
        drive_reg <= drive_next;
    end

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kp_reg      <= '0;
            ki_reg      <= '0;
            kd_reg      <= '0;
            dt_reg      <= TIME_W'(65536);
            dt_rcp_reg  <= TIME_W'(65536);
            out_max_reg <= 32'sh7FFF_FFFF;
            out_min_reg <= 32'sh8000_0000;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_KP:      kp_reg      <= cfg_data;
                REG_KI:      ki_reg      <= cfg_data;
                REG_KD:      kd_reg      <= cfg_data;
                REG_DT:      dt_reg      <= cfg_data[TIME_W-1:0];
                REG_DT_RCP:  dt_rcp_reg  <= cfg_data[TIME_W-1:0];
                REG_OUT_MAX: out_max_reg <= cfg_data;
                REG_OUT_MIN: out_min_reg <= cfg_data;
                default:     kp_reg      <= kp_reg;
            endcase
        end
    end

endmodule
